// ===== design/vfv_pkg.sv =====
// vfv_pkg: shared types and constants of the voxel face visibility block.
// No dependencies; imported by vfv_ctrl, vfv_datapath and the top level.

package vfv_pkg;

  // Field widths of the request and result items
  localparam int COORD_W   = 4;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int MASK_W    = 6;
  localparam int COUNT_W   = 3;
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 16;

  // Request kinds carried on s_axis_tuser
  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;
  localparam logic [CFG_W-1:0]     SIZE_RESET = 5'd16;

  // Bit positions of the faces in the visibility mask
  localparam int FACE_NX = 0;
  localparam int FACE_PZ = 1;
  localparam int FACE_PX = 2;
  localparam int FACE_NZ = 3;
  localparam int FACE_NY = 4;
  localparam int FACE_PY = 5;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;  // request accepted, first pair of row reads issued
    logic ph1;   // second pair of row reads issued
    logic ph2;   // last row read issued
    logic fin;   // result and row write committed
  } vfv_cmd_t;

endpackage

// ===== design/vfv_ram.sv =====
// vfv_ram: generic RAM, one write port and two read ports with registered read data.
// No dependencies.

module vfv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         q_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         q_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      q_a <= mem[raddr_a];
    end
    if (re_b) begin
      q_b <= mem[raddr_b];
    end
  end

endmodule

// ===== design/vfv_ctrl.sv =====
// vfv_ctrl: sequencing state machine of the voxel face visibility block.
// Depends on vfv_pkg for the command struct.

module vfv_ctrl import vfv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_free,
  output vfv_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_FIN
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= S_RD1;
            in_ready <= 1'b0;
          end
        end
        S_RD1: state <= S_RD2;
        S_RD2: state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.load = in_valid && in_ready;
    case (state)
      S_RD1:   cmd.ph1 = 1'b1;
      S_RD2:   cmd.ph2 = 1'b1;
      S_FIN:   cmd.fin = out_free;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE)
    else $error("ready raised outside idle");

  a_read_sequence: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.ph1 ##1 cmd.ph2)
    else $error("row read sequence broken");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one command in a cycle");
`endif

endmodule

// ===== design/vfv_datapath.sv =====
// vfv_datapath: request latch, row reads, face visibility logic and result register.
// Depends on vfv_pkg and vfv_ram.

module vfv_datapath import vfv_pkg::*; #(
  parameter int MAX_SIDE = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  vfv_cmd_t             cmd,
  input  logic [S_TDATA_W-1:0] in_data,
  input  logic                 in_kind,
  input  logic [CFG_W-1:0]     size_x,
  input  logic [CFG_W-1:0]     size_y,
  input  logic [CFG_W-1:0]     size_z,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [M_TDATA_W-1:0] out_data,
  output logic                 out_bad,
  output logic                 out_free
);

  localparam int CB_RAW = $clog2(MAX_SIDE);
  localparam int CB     = (CB_RAW < COORD_W) ? CB_RAW : COORD_W;
  localparam int ROWW   = 1 << CB;
  localparam int ROWS   = 1 << (2 * CB);
  localparam int RAW    = 2 * CB;
  localparam int LIM    = (MAX_SIDE < ROWW) ? MAX_SIDE : ROWW;
  localparam int PAD_W  = M_TDATA_W - 1 - MASK_W - COUNT_W;
  localparam logic [CB-1:0]    ONE_R = CB'(1);
  localparam logic [COORD_W:0] ONE_C = (COORD_W+1)'(1);

  function automatic logic in_range(input logic [COORD_W:0] c, input logic [CFG_W-1:0] sz);
    return (c < sz) && (int'(c) < LIM);
  endfunction

  function automatic logic [RAW-1:0] row_of(input logic [CB-1:0] z, input logic [CB-1:0] y);
    return {z, y};
  endfunction

  // Latched request
  action_t            act;
  logic [COORD_W-1:0] cx, cy, cz;
  logic               fil;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action_t'(in_kind);
      cx  <= in_data[COORD_W-1:0];
      cy  <= in_data[2*COORD_W-1:COORD_W];
      cz  <= in_data[3*COORD_W-1:2*COORD_W];
      fil <= in_data[3*COORD_W];
    end
  end

  logic [CB-1:0] in_ys, in_zs, xs, ys, zs;
  assign in_ys = in_data[COORD_W +: CB];
  assign in_zs = in_data[2*COORD_W +: CB];
  assign xs    = cx[CB-1:0];
  assign ys    = cy[CB-1:0];
  assign zs    = cz[CB-1:0];

  // Row reads: center and -y on load, +y and -z next, +z last
  logic            re_a, re_b, ram_we;
  logic [RAW-1:0]  addr_a, addr_b, addr_w;
  logic [ROWW-1:0] q_a, q_b, qa_m, qb_m, wrow;

  assign re_a   = cmd.load || cmd.ph1 || cmd.ph2;
  assign re_b   = cmd.load || cmd.ph1;
  assign addr_a = cmd.load ? row_of(in_zs, in_ys) :
                  cmd.ph1  ? row_of(zs, ys + ONE_R) : row_of(zs + ONE_R, ys);
  assign addr_b = cmd.load ? row_of(in_zs, in_ys - ONE_R) : row_of(zs - ONE_R, ys);
  assign addr_w = row_of(zs, ys);

  vfv_ram #(.WIDTH(ROWW), .DEPTH(ROWS)) u_rows (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (addr_w),
    .wdata   (wrow),
    .re_a    (re_a),
    .raddr_a (addr_a),
    .q_a     (q_a),
    .re_b    (re_b),
    .raddr_b (addr_b),
    .q_b     (q_b)
  );

  // Rows never written since reset read as empty
  logic [ROWS-1:0] row_valid;
  logic            vld_a, vld_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (ram_we) begin
      row_valid[addr_w] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re_a) begin
      vld_a <= row_valid[addr_a];
    end
    if (re_b) begin
      vld_b <= row_valid[addr_b];
    end
  end

  assign qa_m = vld_a ? q_a : '0;
  assign qb_m = vld_b ? q_b : '0;

  logic [ROWW-1:0] row_c, row_ym, row_yp, row_zm;

  always_ff @(posedge clk) begin
    if (cmd.ph1) begin
      row_c  <= qa_m;
      row_ym <= qb_m;
    end
    if (cmd.ph2) begin
      row_yp <= qa_m;
      row_zm <= qb_m;
    end
  end

  // Range checks; the +z row is taken live from the read port
  logic             bad, ctr, present;
  logic             xm_in, xp_in, ym_in, yp_in, zm_in, zp_in;
  logic [MASK_W-1:0]  vis, mask;
  logic [COUNT_W-1:0] count;

  assign bad = !in_range({1'b0, cx}, size_x) || !in_range({1'b0, cy}, size_y) ||
               !in_range({1'b0, cz}, size_z);
  assign xm_in = cx != '0;
  assign ym_in = cy != '0;
  assign zm_in = cz != '0;
  assign xp_in = in_range({1'b0, cx} + ONE_C, size_x);
  assign yp_in = in_range({1'b0, cy} + ONE_C, size_y);
  assign zp_in = in_range({1'b0, cz} + ONE_C, size_z);

  assign ctr = (act == ACT_WRITE) ? fil : row_c[xs];

  always_comb begin
    vis          = '0;
    vis[FACE_NX] = !(xm_in && row_c[xs - ONE_R]);
    vis[FACE_PZ] = !(zp_in && qa_m[xs]);
    vis[FACE_PX] = !(xp_in && row_c[xs + ONE_R]);
    vis[FACE_NZ] = !(zm_in && row_zm[xs]);
    vis[FACE_NY] = !(ym_in && row_ym[xs]);
    vis[FACE_PY] = !(yp_in && row_yp[xs]);
  end

  assign present = !bad && ctr;
  assign mask    = present ? vis : '0;
  assign count   = COUNT_W'($countones(mask));

  always_comb begin
    wrow     = row_c;
    wrow[xs] = fil;
  end

  assign ram_we = cmd.fin && (act == ACT_WRITE) && !bad;

  // Result register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_data <= {{PAD_W{1'b0}}, count, mask, present};
      out_bad  <= bad;
    end
  end

`ifndef SYNTHESIS
  a_bad_clears_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_bad |-> out_data == '0)
    else $error("rejected request carries result data");

  a_write_marks_row: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> row_valid[$past(addr_w)])
    else $error("written row not marked valid");

  a_fin_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> out_free)
    else $error("result committed into a full output register");
`endif

endmodule

// ===== design/voxel_face_visibility_top.sv =====
// voxel_face_visibility_top: top level of the voxel face visibility block.
// Depends on vfv_pkg, vfv_ctrl, vfv_datapath and vfv_ram.
//
// Requests enter on s_axis; s_axis_tuser selects the kind: ACT_WRITE sets or
// clears one cell, ACT_QUERY reads it. Each request gives exactly one result on
// m_axis: whether the cell is occupied, the mask of visible faces (-x, +z, +x,
// -z, -y, +y from bit 0) and its bit count. m_axis_tuser flags a coordinate at
// or beyond the configured size; such a request changes nothing and returns an
// all-zero result. Write sizes through cfg_we/cfg_index/cfg_data only while idle.
//
// A result becomes valid when its request leaves the last step, and the input
// reopens in the same cycle; one request is in work at a time. The five grid
// rows (center, -y, +y, -z, +z) are read through the two read ports of the row
// RAM in steps: center and -y, then +y and -z, then +z. The result register frees
// the input side: the next request is accepted while a finished result still
// waits. If m_axis_tready stays low, the request in work holds in its last step.
//
// Reset returns all sizes to 16 and marks every grid row empty at once through
// per-row valid bits; a request is taken in the first cycle after reset.

module voxel_face_visibility_top import vfv_pkg::*; #(
  parameter int MAX_SIDE = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [3:0] cell_x, [7:4] cell_y, [11:8] cell_z, [12] fill, [15:13] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [0] action
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] present, [6:1] face_mask, [9:7] face_count, [15:10] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // [0] bad_coord
  output logic                 m_axis_tuser,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Grid size registers; an index beyond the list is dropped
  logic [CFG_W-1:0] size_x, size_y, size_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_RESET;
      size_y <= SIZE_RESET;
      size_z <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_X: size_x <= cfg_data;
        REG_SIZE_Y: size_y <= cfg_data;
        REG_SIZE_Z: size_z <= cfg_data;
        default: ;
      endcase
    end
  end

  vfv_cmd_t cmd;
  logic     out_free;

  // Sequencer: advance through the row reads, hold the last step on a stall
  vfv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_free (out_free),
    .cmd      (cmd)
  );

  // Grid storage, visibility logic and the result register
  vfv_datapath #(.MAX_SIDE(MAX_SIDE)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (s_axis_tdata),
    .in_kind   (s_axis_tuser),
    .size_x    (size_x),
    .size_y    (size_y),
    .size_z    (size_z),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_bad   (m_axis_tuser),
    .out_free  (out_free)
  );

endmodule
